FILE: sv/generational_slot_allocator_top_macros.svh
// Assertion macros used by the allocator's top-level RTL.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_TOP_MACROS_SVH

// Checked on every clock edge outside of reset.
`define GSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define GSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: sv/gsa_pkg.sv
package gsa_pkg;

    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int HANDLE_W   = 22;
    localparam int SLOT_OUT_W = 6;

    localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_START_FAIL = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_HANDLE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic                start_ok;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [HANDLE_W-1:0]   handle_out;
        logic [SLOT_OUT_W-1:0] slot_out;
    } out_word_t;

    // Read and write strobes of one memory port pair.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

FILE: sv/generational_slot_allocator_top.sv
// Generational slot allocator. A create reads the free stack at the fill count,
// then the slot table at the popped index, and then writes back and registers
// its result; a destroy, find or rejected request skips the stack read, and only
// a destroy or find reads the slot table. The result waits while the output is
// stalled. After reset the slot table is swept one entry per cycle, and no word
// is taken before the sweep ends. Handles carry the generation above the low
// $clog2(SLOTS) index bits, cut to 22 bits.
`include "generational_slot_allocator_top_macros.svh"

module generational_slot_allocator_top
    import gsa_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int GEN_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_STACK = 3'b010,
        ST_SLOT  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    in_word_t         req_reg, req_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_reg, out_next;

    mem_ctl_t            stk_ctl;
    logic [IDX_W-1:0]    stk_rd_addr;
    logic [IDX_W-1:0]    stk_wr_addr;
    logic [IDX_W-1:0]    stk_rd_data;
    mem_ctl_t            tbl_ctl;
    logic [IDX_W-1:0]    tbl_rd_addr;
    logic [GEN_BITS-1:0] tbl_wr_gen;
    logic                tbl_wr_alive;
    logic [GEN_BITS-1:0] tbl_rd_gen;
    logic                tbl_rd_alive;
    logic                tbl_busy;

    logic                accept;
    logic                full;
    logic [IDX_W-1:0]    in_idx;
    logic                in_idx_ok;
    logic                req_idx_ok;
    logic                hit;
    logic                commit;
    logic [CNT_W-1:0]    used_dec;
    logic [GEN_BITS-1:0] gen_inc;
    logic [GEN_BITS-1:0] gen_new;
    logic [HANDLE_W+GEN_BITS+IDX_W-1:0] handle_wide;
    logic [SLOT_OUT_W+IDX_W-1:0]        slot_wide;

    gsa_free_stack #(
        .SLOTS(SLOTS)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (stk_ctl),
        .rd_addr (stk_rd_addr),
        .wr_addr (stk_wr_addr),
        .wr_data (slot_reg),
        .rd_data (stk_rd_data)
    );

    gsa_slot_table #(
        .SLOTS(SLOTS),
        .GEN_BITS(GEN_BITS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (tbl_ctl),
        .rd_addr  (tbl_rd_addr),
        .wr_addr  (slot_reg),
        .wr_gen   (tbl_wr_gen),
        .wr_alive (tbl_wr_alive),
        .rd_gen   (tbl_rd_gen),
        .rd_alive (tbl_rd_alive),
        .busy     (tbl_busy)
    );

    assign s_ready    = (state_reg == ST_IDLE) && !tbl_busy;
    assign accept     = s_valid && s_ready;
    assign full       = (used_reg == CNT_W'(SLOTS));
    assign in_idx     = s_data.handle[IDX_W-1:0];
    assign in_idx_ok  = ({1'b0, in_idx} < (IDX_W + 1)'(SLOTS));
    assign req_idx_ok = ({1'b0, req_reg.handle[IDX_W-1:0]} < (IDX_W + 1)'(SLOTS));
    assign hit        = (req_reg.handle != '0) && req_idx_ok && tbl_rd_alive;
    assign commit     = (state_reg == ST_SLOT) && (!out_valid_reg || m_ready);
    assign used_dec   = used_reg - CNT_W'(1);
    assign stk_wr_addr = used_dec[IDX_W-1:0];

    // Generations wrap past zero so that a fresh handle is never all zero.
    assign gen_inc     = tbl_rd_gen + GEN_BITS'(1);
    assign gen_new     = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
    assign handle_wide = {{HANDLE_W{1'b0}}, gen_new, slot_reg};
    assign slot_wide   = {{SLOT_OUT_W{1'b0}}, slot_reg};

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        slot_next      = slot_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        stk_ctl        = '0;
        stk_rd_addr    = used_reg[IDX_W-1:0];
        tbl_ctl        = '0;
        tbl_rd_addr    = in_idx;
        tbl_wr_gen     = tbl_rd_gen;
        tbl_wr_alive   = tbl_rd_alive;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next  = s_data;
                    slot_next = in_idx;
                    if (s_data.mode == MODE_CREATE && !full) begin
                        stk_ctl.rd_en = 1'b1;
                        state_next    = ST_STACK;
                    end else begin
                        tbl_ctl.rd_en = ((s_data.mode == MODE_DESTROY) ||
                                         (s_data.mode == MODE_FIND)) && in_idx_ok;
                        state_next    = ST_SLOT;
                    end
                end
            end
            ST_STACK: begin
                slot_next     = stk_rd_data;
                tbl_rd_addr   = stk_rd_data;
                tbl_ctl.rd_en = 1'b1;
                state_next    = ST_SLOT;
            end
            ST_SLOT: begin
                if (commit) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    out_next       = '{status: STATUS_BAD_HANDLE, handle_out: '0,
                                       slot_out: '0};
                    case (req_reg.mode)
                        MODE_CREATE: begin
                            if (full) begin
                                out_next.status = STATUS_NO_FREE;
                            end else begin
                                // A failed start keeps the new generation; the
                                // slot simply stays on top of the stack.
                                tbl_ctl.wr_en = 1'b1;
                                tbl_wr_gen    = gen_new;
                                tbl_wr_alive  = req_reg.start_ok || tbl_rd_alive;
                                if (req_reg.start_ok) begin
                                    used_next           = used_reg + CNT_W'(1);
                                    out_next.status     = STATUS_OK;
                                    out_next.handle_out = handle_wide[HANDLE_W-1:0];
                                    out_next.slot_out   = slot_wide[SLOT_OUT_W-1:0];
                                end else begin
                                    out_next.status = STATUS_START_FAIL;
                                end
                            end
                        end
                        MODE_DESTROY, MODE_FIND: begin
                            if (hit) begin
                                out_next.status     = STATUS_OK;
                                out_next.handle_out = req_reg.handle;
                                out_next.slot_out   = slot_wide[SLOT_OUT_W-1:0];
                                if (req_reg.mode == MODE_DESTROY) begin
                                    tbl_ctl.wr_en = 1'b1;
                                    tbl_wr_alive  = 1'b0;
                                    if (used_reg != '0) begin
                                        used_next     = used_dec;
                                        stk_ctl.wr_en = 1'b1;
                                    end
                                end
                            end
                        end
                        default: begin
                            out_next.status = STATUS_BAD_HANDLE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        slot_reg <= slot_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `GSA_ASSERT(a_used_in_range, used_reg <= CNT_W'(SLOTS), "fill count exceeds slot count")
    `GSA_ASSERT(a_push_pops_count, stk_ctl.wr_en |=> used_reg == $past(used_dec), "push without count drop")
    `GSA_ASSERT(a_no_write_while_clearing, tbl_busy |-> !tbl_ctl.wr_en, "slot write during clear")
    `GSA_ASSERT_ALWAYS(a_reset_blocks_input, !aresetn |=> !s_ready && !m_valid, "ready after reset")

endmodule

FILE: sv/gsa_free_stack.sv
module gsa_free_stack
    import gsa_pkg::*;
#(
    parameter int SLOTS = 64,
    localparam int IDX_W = $clog2(SLOTS),
    localparam int CNT_W = $clog2(SLOTS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  mem_ctl_t         ctl,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [IDX_W-1:0] wr_data,
    output logic [IDX_W-1:0] rd_data
);

    logic [IDX_W-1:0] mem [SLOTS];
    logic [IDX_W-1:0] mem_rd_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             rd_fresh_reg;
    logic [CNT_W-1:0] high_reg;
    logic [CNT_W-1:0] high_next;
    logic [CNT_W-1:0] wr_top;

    // Positions at or above the high mark were never written and read back as
    // their own index, so no clearing pass is needed.
    assign wr_top = {1'b0, wr_addr} + CNT_W'(1);

    always_comb begin
        high_next = high_reg;
        if (ctl.wr_en && (wr_top > high_reg)) begin
            high_next = wr_top;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_reg <= '0;
        end else begin
            high_reg <= high_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            mem_rd_reg   <= mem[rd_addr];
            rd_addr_reg  <= rd_addr;
            rd_fresh_reg <= ({1'b0, rd_addr} >= high_reg);
        end
    end

    assign rd_data = rd_fresh_reg ? rd_addr_reg : mem_rd_reg;

endmodule

FILE: sv/gsa_slot_table.sv
module gsa_slot_table
    import gsa_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int GEN_BITS = 16,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mem_ctl_t            ctl,
    input  logic [IDX_W-1:0]    rd_addr,
    input  logic [IDX_W-1:0]    wr_addr,
    input  logic [GEN_BITS-1:0] wr_gen,
    input  logic                wr_alive,
    output logic [GEN_BITS-1:0] rd_gen,
    output logic                rd_alive,
    output logic                busy
);

    logic [GEN_BITS:0]  mem [SLOTS];
    logic [GEN_BITS:0]  rd_data_reg;
    logic               clr_reg;
    logic               clr_next;
    logic [IDX_W-1:0]   clr_addr_reg;
    logic [IDX_W-1:0]   clr_addr_next;

    // After reset every entry is swept to generation zero and dead.
    always_comb begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg) begin
            clr_addr_next = clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == IDX_W'(SLOTS - 1)) begin
                clr_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (ctl.wr_en) begin
            mem[wr_addr] <= {wr_alive, wr_gen};
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_alive = rd_data_reg[GEN_BITS];
    assign rd_gen   = rd_data_reg[GEN_BITS-1:0];
    assign busy     = clr_reg;

endmodule

FILE: tb/sv/generational_slot_allocator_checker.sv
`timescale 1ns / 1ps

module generational_slot_allocator_checker
    import gsa_pkg::*;
#(
    parameter int SLOT_COUNT = 64,
    parameter int GEN_W = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        mismatches,
    output int        awaiting,
    output int        replies_ok,
    output int        replies_no_free,
    output int        replies_start_fail,
    output int        replies_bad_handle
);

    localparam int INDEX_BITS = $clog2(SLOT_COUNT);

    // Shadow copy of the allocator: free index stack, fill level, per-slot
    // generation and liveness.
    logic [INDEX_BITS-1:0] free_slots [SLOT_COUNT];
    logic [INDEX_BITS:0]   slots_in_use;
    logic [GEN_W-1:0]      slot_gen [SLOT_COUNT];
    logic                  slot_alive [SLOT_COUNT];

    out_word_t expected_replies [$];

    function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] n;
        n = g + 1'b1;
        // Generation zero is never handed out, so the count skips it on wrap.
        if (n == '0) begin
            n = GEN_W'(1);
        end
        return n;
    endfunction

    function out_word_t serve_request(input in_word_t req);
        out_word_t             reply;
        logic [INDEX_BITS-1:0] slot;
        reply = '0;
        reply.status = STATUS_BAD_HANDLE;
        case (req.mode)
            MODE_CREATE: begin
                if (slots_in_use == SLOT_COUNT) begin
                    reply.status = STATUS_NO_FREE;
                end else begin
                    slot = free_slots[slots_in_use];
                    slot_gen[slot] = bump_gen(slot_gen[slot]);
                    if (!req.start_ok) begin
                        // The slot goes straight back on top of the stack,
                        // but keeps the generation it just advanced to.
                        reply.status = STATUS_START_FAIL;
                    end else begin
                        slots_in_use = slots_in_use + 1'b1;
                        slot_alive[slot] = 1'b1;
                        reply.status = STATUS_OK;
                        reply.handle_out = HANDLE_W'({slot_gen[slot], slot});
                        reply.slot_out = SLOT_OUT_W'(slot);
                    end
                end
            end
            MODE_DESTROY, MODE_FIND: begin
                slot = req.handle[INDEX_BITS-1:0];
                // Only liveness counts here; the generation is not compared.
                if (req.handle != '0 && slot_alive[slot]) begin
                    if (req.mode == MODE_DESTROY) begin
                        slot_alive[slot] = 1'b0;
                        if (slots_in_use != 0) begin
                            slots_in_use = slots_in_use - 1'b1;
                            free_slots[slots_in_use] = slot;
                        end
                    end
                    reply.status = STATUS_OK;
                    reply.handle_out = req.handle;
                    reply.slot_out = SLOT_OUT_W'(slot);
                end
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        out_word_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                free_slots[i] = INDEX_BITS'(i);
                slot_gen[i] = '0;
                slot_alive[i] = 1'b0;
            end
            slots_in_use = '0;
            expected_replies.delete();
        end else begin
            // A word accepted at this edge cannot be answered at the same edge,
            // so the reply side is settled first.
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected reply, expected none, got 0x%0h", $time, m_data);
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", want.status, m_data.status);
                    check_field("handle_out", want.handle_out, m_data.handle_out);
                    check_field("slot_out", want.slot_out, m_data.slot_out);
                    case (want.status)
                        STATUS_OK:         replies_ok++;
                        STATUS_NO_FREE:    replies_no_free++;
                        STATUS_START_FAIL: replies_start_fail++;
                        default:           replies_bad_handle++;
                    endcase
                end
            end
            if (s_valid && s_ready) begin
                expected_replies.push_back(serve_request(s_data));
            end
        end
        awaiting = expected_replies.size();
    end

endmodule

FILE: tb/sv/tb_generational_slot_allocator_top.sv
`timescale 1ns / 1ps

module tb_generational_slot_allocator_top;
    import gsa_pkg::*;

    localparam int SLOTS = 64;
    localparam int GEN_BITS = 16;
    localparam int INDEX_BITS = $clog2(SLOTS);
    localparam int RANDOM_WORDS = 1100;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 20;

    // The one mode code that the block does not define.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    int mismatches;
    int awaiting;
    int replies_ok;
    int replies_no_free;
    int replies_start_fail;
    int replies_bad_handle;

    int words_sent = 0;
    int random_sent = 0;
    int gap_free_left = 0;

    // Handles handed out by the block, and handles that were destroyed since.
    logic [HANDLE_W-1:0] live_handles [$];
    logic [HANDLE_W-1:0] retired_handles [$];
    logic [MODE_W-1:0]   modes_in_flight [$];

    always #5 aclk = ~aclk;

    generational_slot_allocator_top #(
        .SLOTS(SLOTS),
        .GEN_BITS(GEN_BITS)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    generational_slot_allocator_checker #(
        .SLOT_COUNT(SLOTS),
        .GEN_W(GEN_BITS)
    ) u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .mismatches(mismatches),
        .awaiting(awaiting),
        .replies_ok(replies_ok),
        .replies_no_free(replies_no_free),
        .replies_start_fail(replies_start_fail),
        .replies_bad_handle(replies_bad_handle)
    );

    // Learn new handles from successful creates so that later destroys and
    // finds can name slots that are actually alive.
    always @(posedge aclk) begin : handle_harvest
        logic [MODE_W-1:0] mode_done;
        if (aresetn && m_valid && m_ready && modes_in_flight.size() != 0) begin
            mode_done = modes_in_flight.pop_front();
            if (mode_done == MODE_CREATE && m_data.status == STATUS_OK) begin
                live_handles.push_back(m_data.handle_out);
            end
        end
    end

    function automatic in_word_t make_word(input logic [MODE_W-1:0] mode,
                                           input logic [HANDLE_W-1:0] handle,
                                           input logic start_ok);
        in_word_t w;
        w.mode = mode;
        w.handle = handle;
        w.start_ok = start_ok;
        return w;
    endfunction

    function automatic int sender_gap();
        int r;
        if (gap_free_left > 0) begin
            gap_free_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            gap_free_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic in_word_t random_request(input int create_pct);
        in_word_t            w;
        int                  r;
        int                  k;
        logic [HANDLE_W-1:0] picked;
        logic [HANDLE_W-INDEX_BITS-1:0] other_gen;
        w.mode = MODE_CREATE;
        w.handle = HANDLE_W'($urandom);
        w.start_ok = ($urandom_range(0, 9) != 0);
        r = $urandom_range(0, 99);
        if (r < create_pct) begin
            return w;
        end
        if (r >= 95) begin
            // Noise: the unused mode, or a lookup of an arbitrary handle.
            w.mode = ($urandom_range(0, 1) == 0) ? MODE_UNUSED : MODE_FIND;
            return w;
        end
        w.mode = ($urandom_range(0, 1) == 0) ? MODE_DESTROY : MODE_FIND;
        r = $urandom_range(0, 99);
        if (r < 75 && live_handles.size() != 0) begin
            k = $urandom_range(0, live_handles.size() - 1);
            picked = live_handles[k];
            if (w.mode == MODE_DESTROY) begin
                live_handles.delete(k);
                retired_handles.push_back(picked);
                if (retired_handles.size() > SLOTS) begin
                    retired_handles.delete(0);
                end
            end
            w.handle = picked;
        end else if (r < 85 && retired_handles.size() != 0) begin
            w.handle = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
        end else if (r < 95 && live_handles.size() != 0) begin
            // Right slot, wrong generation.
            other_gen = (HANDLE_W - INDEX_BITS)'($urandom);
            picked = live_handles[$urandom_range(0, live_handles.size() - 1)];
            w.handle = {other_gen, picked[INDEX_BITS-1:0]};
        end
        return w;
    endfunction

    task automatic send_word(input in_word_t w, input bit with_gaps);
        int gap;
        gap = with_gaps ? sender_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        modes_in_flight.push_back(w.mode);
        words_sent++;
    endtask

    initial begin : result_sink
        int span;
        int holds_done;
        holds_done = 0;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if ((holds_done == 0 && random_sent >= 300) ||
                (holds_done == 1 && random_sent >= 800)) begin
                // Hold off long enough for the block to back up into its input.
                holds_done++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if ($urandom_range(0, 99) < 60) begin
                    m_ready <= 1'b1;
                    span = $urandom_range(1, 30);
                end else begin
                    m_ready <= 1'b0;
                    span = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 40);
                end
                repeat (span) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int create_pct;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening. Slot 0 is popped first and slot 1 next.
        send_word(make_word(MODE_FIND, 22'h000000, 1'b0), 1'b1);
        send_word(make_word(MODE_DESTROY, 22'h3FFFFF, 1'b1), 1'b1);
        send_word(make_word(MODE_CREATE, 22'h3FFFFF, 1'b1), 1'b1);
        send_word(make_word(MODE_FIND, 22'h000000, 1'b1), 1'b1);
        send_word(make_word(MODE_FIND, 22'h000040, 1'b0), 1'b1);
        send_word(make_word(MODE_FIND, 22'h3FFFC0, 1'b0), 1'b1);
        send_word(make_word(MODE_CREATE, 22'h000000, 1'b0), 1'b1);
        send_word(make_word(MODE_CREATE, 22'h155555, 1'b1), 1'b1);
        send_word(make_word(MODE_UNUSED, 22'h3FFFFF, 1'b1), 1'b1);
        send_word(make_word(MODE_UNUSED, 22'h000000, 1'b0), 1'b1);
        send_word(make_word(MODE_DESTROY, 22'h000081, 1'b0), 1'b1);
        send_word(make_word(MODE_DESTROY, 22'h000081, 1'b0), 1'b1);
        send_word(make_word(MODE_FIND, 22'h000081, 1'b0), 1'b1);
        send_word(make_word(MODE_DESTROY, 22'h3FFFC0, 1'b0), 1'b1);
        send_word(make_word(MODE_FIND, 22'h000040, 1'b1), 1'b1);

        // Alternate between filling the table and draining it, so that the
        // stack runs empty several times.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            create_pct = ((i / 160) % 2 == 0) ? 70 : 25;
            send_word(random_request(create_pct), 1'b1);
            random_sent++;
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests, %0d of them random after the directed opening.",
                 words_sent, random_sent);
        $display("Replies: %0d ok, %0d no free slot, %0d start failed, %0d bad handle.",
                 replies_ok, replies_no_free, replies_start_fail, replies_bad_handle);
        if (mismatches == 0) begin
            $display("** generational_slot_allocator_top: PASSED **");
        end else begin
            $display("** generational_slot_allocator_top: FAILED **");
        end
        $finish;
    end

    // Ends the run as failed if it has not finished by this time, even allowing
    // for the longest gaps and stalls.
    initial begin : watchdog
        #5_000_000;
        $display("Timeout with %0d replies outstanding.", awaiting);
        $display("** generational_slot_allocator_top: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/gsa_pkg.sv
sv/gsa_free_stack.sv
sv/gsa_slot_table.sv
sv/generational_slot_allocator_top.sv
tb/sv/generational_slot_allocator_checker.sv
tb/sv/tb_generational_slot_allocator_top.sv
